// ----- hdl/etfp_pkg.sv -----
// Shared types, constants and colour ramp for the escape-time fractal pixel block.
package etfp_pkg;

    localparam int CFG_WIDTH    = 16;
    localparam int LIMIT_RESET  = 128;
    localparam int MOD_WIDTH    = 7;
    localparam int COLOUR_LAST  = 95;
    localparam int LEVEL_MAX    = 31;
    localparam int LEVEL_SHIFT  = 3;
    localparam int SEG_GREEN    = 1;
    localparam int SEG_BLUE     = 2;
    localparam int SEG_RED      = 0;

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_MUL  = 4'b0010,
        ST_UPD  = 4'b0100,
        ST_DONE = 4'b1000
    } state_t;

    typedef struct packed {
        logic load;
        logic mul;
        logic upd;
        logic result_load;
    } cmd_t;

    typedef struct packed {
        logic run;
    } sts_t;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } rgb_t;

    // m is the iteration count modulo 96; each 32-step segment ramps two channels
    function automatic rgb_t colour_ramp(input logic [MOD_WIDTH-1:0] m);
        rgb_t       c;
        logic [4:0] lvl;
        logic [4:0] inv;
        lvl = m[4:0];
        inv = 5'(LEVEL_MAX) - lvl;
        c   = '0;
        case (32'(m[6:5]))
            SEG_RED:
            begin
                c.red   = {inv, LEVEL_SHIFT'(0)};
                c.green = {lvl, LEVEL_SHIFT'(0)};
            end
            SEG_GREEN:
            begin
                c.green = {inv, LEVEL_SHIFT'(0)};
                c.blue  = {lvl, LEVEL_SHIFT'(0)};
            end
            SEG_BLUE:
            begin
                c.red   = {lvl, LEVEL_SHIFT'(0)};
                c.blue  = {inv, LEVEL_SHIFT'(0)};
            end
            default:
            begin
                c = '0;
            end
        endcase
        return c;
    endfunction

endpackage

// ----- hdl/etfp_ctrl.sv -----
// Sequencing state machine for the escape-time iteration and output hand-off.
module etfp_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    output logic             out_valid,
    input  logic             out_ready,
    input  etfp_pkg::sts_t   sts,
    output etfp_pkg::cmd_t   cmd
);

    etfp_pkg::state_t state_reg;
    etfp_pkg::state_t state_next;
    logic             out_valid_reg;
    logic             out_valid_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            etfp_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = etfp_pkg::ST_MUL;
                end
            end
            etfp_pkg::ST_MUL:
            begin
                cmd.mul = 1'b1;
                if (sts.run)
                begin
                    state_next = etfp_pkg::ST_UPD;
                end
                else
                begin
                    state_next = etfp_pkg::ST_DONE;
                end
            end
            etfp_pkg::ST_UPD:
            begin
                cmd.upd    = 1'b1;
                state_next = etfp_pkg::ST_MUL;
            end
            etfp_pkg::ST_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.result_load = 1'b1;
                    state_next      = etfp_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = etfp_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (cmd.result_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= etfp_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_ready  = (state_reg == etfp_pkg::ST_IDLE);
    assign out_valid = out_valid_reg;

endmodule

// ----- hdl/etfp_datapath.sv -----
// Datapath: z registers, three product registers, counters and result register.
module etfp_datapath #(
    parameter int COORD_WIDTH = 32,
    parameter int FRAC_BITS   = 28,
    parameter int COUNT_WIDTH = 16
) (
    input  logic                          clk,
    input  etfp_pkg::cmd_t                cmd,
    output etfp_pkg::sts_t                sts,
    input  logic signed [COORD_WIDTH-1:0] coord_imag_seed,
    input  logic signed [COORD_WIDTH-1:0] coord_real_seed,
    input  logic [COUNT_WIDTH-1:0]        limit,
    output logic [7:0]                    red,
    output logic [7:0]                    green,
    output logic [7:0]                    blue,
    output logic [15:0]                   iterations,
    output logic                          inside_res
);

    localparam int ZW = (COORD_WIDTH > FRAC_BITS + 7) ? COORD_WIDTH : FRAC_BITS + 7;
    localparam int MW = FRAC_BITS + 3;
    localparam int PW = 2 * MW;
    localparam int EW = ZW + PW;
    localparam logic signed [ZW-1:0] FOUR = ZW'(4) << FRAC_BITS;
    localparam logic signed [ZW-1:0] NEG_FOUR = -FOUR;

    logic signed [ZW-1:0]          c_re_reg;
    logic signed [ZW-1:0]          c_im_reg;
    logic signed [ZW-1:0]          zr_reg;
    logic signed [ZW-1:0]          zr_next;
    logic signed [ZW-1:0]          zi_reg;
    logic signed [ZW-1:0]          zi_next;
    logic signed [PW-1:0]          sq_re_reg;
    logic signed [PW-1:0]          sq_re_next;
    logic signed [PW-1:0]          sq_im_reg;
    logic signed [PW-1:0]          sq_im_next;
    logic signed [PW-1:0]          cross_reg;
    logic signed [PW-1:0]          cross_next;
    logic [COUNT_WIDTH-1:0]        count_reg;
    logic [etfp_pkg::MOD_WIDTH-1:0] mod_reg;
    logic [etfp_pkg::MOD_WIDTH-1:0] mod_next;
    logic signed [MW-1:0]          zr_m;
    logic signed [MW-1:0]          zi_m;
    logic signed [EW-1:0]          re_sum;
    logic signed [EW-1:0]          im_sum;
    logic                          in_box;
    logic                          inside_next;
    etfp_pkg::rgb_t                rgb;
    logic [7:0]                    red_reg;
    logic [7:0]                    green_reg;
    logic [7:0]                    blue_reg;
    logic [15:0]                   iter_reg;
    logic                          inside_reg;

    // operands are inside the box whenever the products are used
    assign zr_m = zr_reg[MW-1:0];
    assign zi_m = zi_reg[MW-1:0];

    assign sq_re_next = PW'(zr_m) * PW'(zr_m);
    assign sq_im_next = PW'(zi_m) * PW'(zi_m);
    assign cross_next = PW'(zr_m) * PW'(zi_m);

    assign re_sum = EW'(c_re_reg) + (EW'(sq_re_reg) >>> FRAC_BITS)
                  - (EW'(sq_im_reg) >>> FRAC_BITS);
    assign im_sum = EW'(c_im_reg) + (EW'(cross_reg) >>> (FRAC_BITS - 1));

    assign zr_next = re_sum[ZW-1:0];
    assign zi_next = im_sum[ZW-1:0];

    assign in_box = (zr_reg > NEG_FOUR) && (zr_reg < FOUR)
                 && (zi_reg > NEG_FOUR) && (zi_reg < FOUR);
    assign sts.run = in_box && (count_reg < limit);

    assign mod_next = (mod_reg == etfp_pkg::MOD_WIDTH'(etfp_pkg::COLOUR_LAST))
                    ? '0 : mod_reg + 1'b1;

    assign inside_next = (count_reg == limit);
    assign rgb         = etfp_pkg::colour_ramp(mod_reg);

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            c_re_reg  <= ZW'(coord_real_seed);
            c_im_reg  <= ZW'(coord_imag_seed);
            zr_reg    <= ZW'(coord_real_seed);
            zi_reg    <= ZW'(coord_imag_seed);
            count_reg <= '0;
            mod_reg   <= '0;
        end
        else if (cmd.upd)
        begin
            zr_reg    <= zr_next;
            zi_reg    <= zi_next;
            count_reg <= count_reg + 1'b1;
            mod_reg   <= mod_next;
        end
        if (cmd.mul)
        begin
            sq_re_reg <= sq_re_next;
            sq_im_reg <= sq_im_next;
            cross_reg <= cross_next;
        end
        if (cmd.result_load)
        begin
            inside_reg <= inside_next;
            iter_reg   <= 16'(count_reg);
            red_reg    <= inside_next ? 8'd0 : rgb.red;
            green_reg  <= inside_next ? 8'd0 : rgb.green;
            blue_reg   <= inside_next ? 8'd0 : rgb.blue;
        end
    end

    assign red        = red_reg;
    assign green      = green_reg;
    assign blue       = blue_reg;
    assign iterations = iter_reg;
    assign inside_res = inside_reg;

endmodule

// ----- hdl/escape_time_fractal_pixel_top.sv -----
// Each iteration passes through the MUL state, through the three parallel multipliers,
// then UPD, for the add/subtract into z; escape and limit checks share the MUL state.
// Inputs transfer only in IDLE, after the last result is loaded, even while it still waits.
// Reset: idle, no result pending, iteration_limit = 128.
// Top level of the escape-time fractal pixel block.
module escape_time_fractal_pixel_top #(
    parameter int COORD_WIDTH = 32,
    parameter int FRAC_BITS   = 28,
    parameter int COUNT_WIDTH = 16
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic signed [COORD_WIDTH-1:0]      coord_imag_seed,
    input  logic signed [COORD_WIDTH-1:0]      coord_real_seed,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic [7:0]                         red,
    output logic [7:0]                         green,
    output logic [7:0]                         blue,
    output logic [15:0]                        iterations,
    output logic                               inside_res,
    input  logic                               cfg_wr_en,
    input  logic [etfp_pkg::CFG_WIDTH-1:0]     cfg_wr_data
);

    logic [etfp_pkg::CFG_WIDTH-1:0] limit_reg;
    logic [etfp_pkg::CFG_WIDTH-1:0] limit_next;
    etfp_pkg::cmd_t                 cmd;
    etfp_pkg::sts_t                 sts;

    assign limit_next = cfg_wr_en ? cfg_wr_data : limit_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg <= etfp_pkg::CFG_WIDTH'(etfp_pkg::LIMIT_RESET);
        end
        else
        begin
            limit_reg <= limit_next;
        end
    end

    etfp_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    etfp_datapath #(
        .COORD_WIDTH (COORD_WIDTH),
        .FRAC_BITS   (FRAC_BITS),
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_datapath (
        .clk             (clk),
        .cmd             (cmd),
        .sts             (sts),
        .coord_imag_seed (coord_imag_seed),
        .coord_real_seed (coord_real_seed),
        .limit           (limit_reg[COUNT_WIDTH-1:0]),
        .red             (red),
        .green           (green),
        .blue            (blue),
        .iterations      (iterations),
        .inside_res      (inside_res)
    );

    a_busy_after_transfer: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input ready while a point is being iterated");

    a_inside_black: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && inside_res |-> (red == 8'd0) && (green == 8'd0) && (blue == 8'd0))
        else $error("inside point not black");

    a_outside_coloured: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !inside_res |-> (red | green | blue) != 8'd0)
        else $error("escaped point has no colour");

    a_result_load_slot: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.result_load |-> !out_valid || out_ready)
        else $error("result register overwritten before transfer");

endmodule
